@@ hw/rtl/tda_pkg.sv @@
// -----------------------------------------------------------------------------
// tda_pkg
// Shared types, codes and arithmetic helpers for the 2D diagonal assembly block.
// -----------------------------------------------------------------------------
package tda_pkg;

   localparam int unsigned MAX_DOF_DEF  = 8;
   localparam int unsigned MAX_QUAD_DEF = 8;
   localparam int unsigned QUEUE_DEPTH  = 2;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned ACC_W   = 64;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned CFG_W   = 4;
   localparam int unsigned FRAC_W  = 16;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // Operation codes on the request channel.
   localparam logic [1:0] OP_LOAD_BASIS = 2'd0;
   localparam logic [1:0] OP_LOAD_HESS  = 2'd1;
   localparam logic [1:0] OP_QUERY      = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_NUM_DOFS = 1'b0;
   localparam logic CSR_NUM_QUAD = 1'b1;

   localparam logic signed [ACC_W-1:0] POS_LIMIT = 64'sd2147483647;
   localparam logic signed [ACC_W-1:0] NEG_LIMIT = -64'sd2147483648;

   typedef enum logic [1:0] {
      CMD_BASIS,
      CMD_HESS,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic                      component;
      logic [IDX_W-1:0]          index_a;
      logic [IDX_W-1:0]          index_b;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_MULT,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      clipped;
      logic signed [VALUE_W-1:0] value;
   } sat_type;

   // Floor division by 2^16 of a Q32.32 product back to Q16.16 scale.
   function automatic logic signed [ACC_W-1:0] fshift(input logic signed [ACC_W-1:0] x);
      return x >>> FRAC_W;
   endfunction

   // Saturate to the signed 32-bit range and report whether clipping happened.
   function automatic sat_type sat32(input logic signed [ACC_W-1:0] x);
      sat_type r;
      if (x > POS_LIMIT) begin
         r.clipped = 1'b1;
         r.value   = 32'sh7FFFFFFF;
      end else if (x < NEG_LIMIT) begin
         r.clipped = 1'b1;
         r.value   = 32'sh80000000;
      end else begin
         r.clipped = 1'b0;
         r.value   = x[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/tda_front.sv @@
// -----------------------------------------------------------------------------
// tda_front
// Accepts request transfers, drops ignored ones and classifies the rest.
// -----------------------------------------------------------------------------
module tda_front #(
   parameter int unsigned MAX_DOF  = tda_pkg::MAX_DOF_DEF,
   parameter int unsigned MAX_QUAD = tda_pkg::MAX_QUAD_DEF
) (
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_operation,
   input  logic                             req_component,
   input  logic [tda_pkg::IDX_W-1:0]        req_index_a,
   input  logic [tda_pkg::IDX_W-1:0]        req_index_b,
   input  logic signed [tda_pkg::VALUE_W-1:0] req_value,
   input  logic                             queue_full,
   output logic                             push,
   output tda_pkg::cmd_type                 push_cmd
);

   logic keep;

   always_comb begin
      keep          = 1'b0;
      push_cmd.kind = tda_pkg::CMD_QUERY;
      case (req_operation)
         tda_pkg::OP_LOAD_BASIS: begin
            push_cmd.kind = tda_pkg::CMD_BASIS;
            keep = (int'(req_index_a) < MAX_QUAD) && (int'(req_index_b) < MAX_DOF);
         end
         tda_pkg::OP_LOAD_HESS: begin
            push_cmd.kind = tda_pkg::CMD_HESS;
            keep = (int'(req_index_a) < MAX_QUAD) && (int'(req_index_b) < MAX_QUAD);
         end
         tda_pkg::OP_QUERY: begin
            push_cmd.kind = tda_pkg::CMD_QUERY;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      push_cmd.component = req_component;
      push_cmd.index_a   = req_index_a;
      push_cmd.index_b   = req_index_b;
      push_cmd.value     = req_value;
   end

   // Transfers that do nothing are still taken, they just never reach the queue.
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready && keep;

endmodule

@@ hw/rtl/tda_queue.sv @@
// -----------------------------------------------------------------------------
// tda_queue
// Short command queue between the front and back parts.
// -----------------------------------------------------------------------------
module tda_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tda_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output tda_pkg::cmd_type pop_cmd,
   output logic             empty
);

   localparam int unsigned DEPTH = tda_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned NW    = $clog2(DEPTH + 1);

   tda_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == NW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = NW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = NW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/tda_back.sv @@
// -----------------------------------------------------------------------------
// tda_back
// Holds the basis and Hessian stores and runs queries on one shared MAC.
// -----------------------------------------------------------------------------
module tda_back #(
   parameter int unsigned MAX_DOF  = tda_pkg::MAX_DOF_DEF,
   parameter int unsigned MAX_QUAD = tda_pkg::MAX_QUAD_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  tda_pkg::cmd_type                   cmd,
   input  logic [tda_pkg::CFG_W-1:0]          num_dofs,
   input  logic [tda_pkg::CFG_W-1:0]          num_quad,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tda_pkg::VALUE_W-1:0] rsp_diag_value,
   output logic                               rsp_saturated
);

   localparam int unsigned CW          = $clog2(MAX_QUAD + 1);
   localparam int unsigned BASIS_DEPTH = MAX_QUAD * MAX_DOF;
   localparam int unsigned HESS_DEPTH  = 2 * MAX_QUAD * MAX_QUAD;
   localparam int unsigned BAW         = $clog2(BASIS_DEPTH);
   localparam int unsigned HAW         = $clog2(HESS_DEPTH);
   localparam int unsigned VW          = tda_pkg::VALUE_W;
   localparam int unsigned AW          = tda_pkg::ACC_W;
   localparam int unsigned IW          = tda_pkg::IDX_W;

   logic [VW-1:0] basis_mem [BASIS_DEPTH];
   logic [VW-1:0] hess_mem  [HESS_DEPTH];

   tda_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        qx_ff, qx_in, qy_ff, qy_in;
   logic                 outer_ff, outer_in;
   logic                 comp_ff, comp_in;
   logic [IW-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic signed [VW-1:0] prior_ff, prior_in;
   logic signed [AW-1:0] qd_ff, qd_in, sum_ff, sum_in, prod_ff, prod_in;
   logic signed [VW-1:0] qdc_ff, qdc_in;
   logic                 flag_ff, flag_in;
   logic signed [VW-1:0] basis_rd_ff, hess_rd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic [CW-1:0]        nq;
   logic                 dofs_ok;
   logic                 basis_we, hess_we, rd_en;
   logic [BAW-1:0]       basis_waddr, basis_raddr;
   logic [HAW-1:0]       hess_waddr, hess_raddr;
   logic signed [VW-1:0] mul_a, mul_b;
   logic signed [AW-1:0] mul_p, term;
   tda_pkg::sat_type     bb, qd_sat, final_sat;

   assign nq = (int'(num_quad) > MAX_QUAD) ? CW'(MAX_QUAD) : CW'(num_quad);
   assign dofs_ok = (int'(cmd.index_a) < int'(num_dofs)) && (int'(cmd.index_a) < MAX_DOF)
                 && (int'(cmd.index_b) < int'(num_dofs)) && (int'(cmd.index_b) < MAX_DOF);

   assign basis_waddr = BAW'(int'(cmd.index_a) * MAX_DOF + int'(cmd.index_b));
   assign hess_waddr  = HAW'((int'(cmd.component) * MAX_QUAD + int'(cmd.index_a)) * MAX_QUAD
                             + int'(cmd.index_b));
   assign basis_raddr = outer_ff ? BAW'(int'(qx_ff) * MAX_DOF + int'(dx_ff))
                                 : BAW'(int'(qy_ff) * MAX_DOF + int'(dy_ff));
   assign hess_raddr  = HAW'((int'(comp_ff) * MAX_QUAD + int'(qx_ff)) * MAX_QUAD
                             + int'(qy_ff));

   // The square of a basis entry is formed again each time it is needed.
   assign bb    = tda_pkg::sat32(tda_pkg::fshift(prod_ff));
   assign mul_a = (state_ff == tda_pkg::ST_MULT) ? bb.value : basis_rd_ff;
   assign mul_b = (state_ff == tda_pkg::ST_MULT) ? (outer_ff ? qdc_ff : hess_rd_ff)
                                                 : basis_rd_ff;
   assign mul_p = AW'(mul_a) * AW'(mul_b);
   assign term  = tda_pkg::fshift(prod_ff);

   assign qd_sat    = tda_pkg::sat32(qd_ff + term);
   assign final_sat = tda_pkg::sat32(AW'(prior_ff) + sum_ff);

   assign cmd_ready = (state_ff == tda_pkg::ST_IDLE);
   assign rd_en     = (state_ff == tda_pkg::ST_READ);

   always_comb begin
      state_in     = state_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      outer_in     = outer_ff;
      comp_in      = comp_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prior_in     = prior_ff;
      qd_in        = qd_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      qdc_in       = qdc_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      basis_we     = 1'b0;
      hess_we      = 1'b0;

      case (state_ff)
         tda_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  tda_pkg::CMD_BASIS: begin
                     basis_we = 1'b1;
                  end
                  tda_pkg::CMD_HESS: begin
                     hess_we = 1'b1;
                  end
                  tda_pkg::CMD_QUERY: begin
                     comp_in  = cmd.component;
                     dx_in    = cmd.index_a;
                     dy_in    = cmd.index_b;
                     prior_in = cmd.value;
                     qx_in    = '0;
                     qy_in    = '0;
                     outer_in = 1'b0;
                     qd_in    = '0;
                     sum_in   = '0;
                     flag_in  = 1'b0;
                     state_in = (dofs_ok && (nq != '0)) ? tda_pkg::ST_READ
                                                        : tda_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = tda_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         tda_pkg::ST_READ: begin
            state_in = tda_pkg::ST_SQUARE;
         end
         tda_pkg::ST_SQUARE: begin
            prod_in  = mul_p;
            state_in = tda_pkg::ST_MULT;
         end
         tda_pkg::ST_MULT: begin
            prod_in  = mul_p;
            flag_in  = flag_ff | bb.clipped;
            state_in = tda_pkg::ST_ACC;
         end
         tda_pkg::ST_ACC: begin
            state_in = tda_pkg::ST_READ;
            if (!outer_ff) begin
               qd_in = qd_ff + term;
               if (CW'(qy_ff + 1'b1) == nq) begin
                  qdc_in   = qd_sat.value;
                  flag_in  = flag_ff | qd_sat.clipped;
                  outer_in = 1'b1;
               end else begin
                  qy_in = CW'(qy_ff + 1'b1);
               end
            end else begin
               sum_in   = sum_ff + term;
               qd_in    = '0;
               qy_in    = '0;
               outer_in = 1'b0;
               if (CW'(qx_ff + 1'b1) == nq) begin
                  state_in = tda_pkg::ST_DONE;
               end else begin
                  qx_in = CW'(qx_ff + 1'b1);
               end
            end
         end
         tda_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = final_sat.value;
               rsp_sat_in   = flag_ff | final_sat.clipped;
               state_in     = tda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tda_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      outer_ff     <= outer_in;
      comp_ff      <= comp_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      prior_ff     <= prior_in;
      qd_ff        <= qd_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      qdc_ff       <= qdc_in;
      flag_ff      <= flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (basis_we) begin
         basis_mem[basis_waddr] <= cmd.value;
      end
      if (rd_en) begin
         basis_rd_ff <= basis_mem[basis_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (hess_we) begin
         hess_mem[hess_waddr] <= cmd.value;
      end
      if (rd_en) begin
         hess_rd_ff <= hess_mem[hess_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_diag_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

@@ hw/rtl/tensor_diag_assembly_2d.sv @@
// -----------------------------------------------------------------------------
// tensor_diag_assembly_2d
// Assembles one element's 2D diagonal by sum factorization in Q16.16.
// -----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_valid/req_ready    basis load, Hessian load, query
//   rsp_      out        rsp_valid/rsp_ready    diagonal value, saturated flag
//   csr_      in         csr_write_enable       num_dofs (0), num_quad (1)
//
// Every request transfer is taken by the front; queries and in-range loads
// enter a two-entry command queue, while unused operations and out-of-range
// loads are dropped at the front. The back part retires a load as soon as
// it pops it. A query runs each product on the shared multiply-accumulate
// unit through its read, square, multiply and accumulate states: nq*nq
// inner products plus nq outer products. A query with a dof out of range or
// nq zero skips to ST_DONE. The result sits in an output register, so the
// queue keeps taking transfers while a result waits on rsp_ready.
// Reset is synchronous; the stores are not cleared and hold garbage until
// written, and both configuration registers come up at 8.
// -----------------------------------------------------------------------------
module tensor_diag_assembly_2d #(
   parameter int unsigned MAX_DOF  = tda_pkg::MAX_DOF_DEF,
   parameter int unsigned MAX_QUAD = tda_pkg::MAX_QUAD_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_operation,
   input  logic                               req_component,
   input  logic [tda_pkg::IDX_W-1:0]          req_index_a,
   input  logic [tda_pkg::IDX_W-1:0]          req_index_b,
   input  logic signed [tda_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tda_pkg::VALUE_W-1:0] rsp_diag_value,
   output logic                               rsp_saturated,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [tda_pkg::CFG_W-1:0]          csr_write_data
);

   logic                       queue_full, queue_empty, push, pop_ready;
   tda_pkg::cmd_type           push_cmd, pop_cmd;
   logic [tda_pkg::CFG_W-1:0]  num_dofs_ff, num_dofs_in;
   logic [tda_pkg::CFG_W-1:0]  num_quad_ff, num_quad_in;

   // Configuration registers. Software must write them only while the block is idle; nothing enforces it.
   always_comb begin
      num_dofs_in = num_dofs_ff;
      num_quad_in = num_quad_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tda_pkg::CSR_NUM_DOFS: num_dofs_in = csr_write_data;
            tda_pkg::CSR_NUM_QUAD: num_quad_in = csr_write_data;
            default: begin
               num_dofs_in = num_dofs_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dofs_ff <= tda_pkg::CFG_RESET;
         num_quad_ff <= tda_pkg::CFG_RESET;
      end else begin
         num_dofs_ff <= num_dofs_in;
         num_quad_ff <= num_quad_in;
      end
   end

   tda_front #(
      .MAX_DOF  (MAX_DOF),
      .MAX_QUAD (MAX_QUAD)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_component (req_component),
      .req_index_a   (req_index_a),
      .req_index_b   (req_index_b),
      .req_value     (req_value),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   tda_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop_ready),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   // The back part pops a command in the same cycle it starts on it.
   tda_back #(
      .MAX_DOF  (MAX_DOF),
      .MAX_QUAD (MAX_QUAD)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (!queue_empty),
      .cmd_ready      (pop_ready),
      .cmd            (pop_cmd),
      .num_dofs       (num_dofs_ff),
      .num_quad       (num_quad_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_diag_value (rsp_diag_value),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

@@ tb/sv/testbench.sv @@
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2D diagonal assembly block: loads basis and
// Hessian stores, issues diagonal queries under several sizes, and checks
// every result against a cycle-free predictor of the sum factorization.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The fourth operation code has no meaning; the block drops it.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // The slowest query and the long hold-off, on top of a few queued queries,
   // stay well inside this bound, so it has ample margin.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS = 108;
   localparam int NUM_PHASES = 12;

   // ---------------------------------------------------------------------------
   // Scoreboard: keeps a copy of both stores and both size registers, predicts
   // the diagonal for each accepted query and matches results in order.
   // ---------------------------------------------------------------------------
   typedef struct {
      logic signed [tda_pkg::VALUE_W-1:0] diag;
      logic                               sat;
   } diag_result_type;

   class diag_scoreboard;
      int                        basis_words[tda_pkg::MAX_DOF_DEF*tda_pkg::MAX_QUAD_DEF];
      int                        hess_words[2*tda_pkg::MAX_QUAD_DEF*tda_pkg::MAX_QUAD_DEF];
      logic [tda_pkg::CFG_W-1:0] dofs_reg;
      logic [tda_pkg::CFG_W-1:0] quad_reg;
      diag_result_type           pending_diag[$];
      int                        errors;

      function void reset_state();
         dofs_reg = tda_pkg::CFG_RESET;
         quad_reg = tda_pkg::CFG_RESET;
         pending_diag.delete();
         errors = 0;
      endfunction

      function void set_size(logic idx, logic [tda_pkg::CFG_W-1:0] data);
         if (idx == tda_pkg::CSR_NUM_DOFS) begin
            dofs_reg = data;
         end else begin
            quad_reg = data;
         end
      endfunction

      function int pending();
         return pending_diag.size();
      endfunction

      function longint clip32(longint x, inout bit flag);
         if (x > longint'(32'sh7FFFFFFF)) begin
            flag = 1'b1;
            return longint'(32'sh7FFFFFFF);
         end
         if (x < -longint'(64'sd2147483648)) begin
            flag = 1'b1;
            return -longint'(64'sd2147483648);
         end
         return x;
      endfunction

      // Square of a basis entry, brought back to Q16.16 and clipped.
      function longint basis_sq(int q, int d, inout bit flag);
         longint b;
         b = basis_words[q*tda_pkg::MAX_DOF_DEF + d];
         return clip32((b * b) >>> tda_pkg::FRAC_W, flag);
      endfunction

      function void note_request(logic [1:0] op, logic v, logic [2:0] a,
                                 logic [2:0] b, logic signed [31:0] val);
         int              nd;
         int              nq;
         bit              flag;
         longint          acc;
         longint          inner;
         longint          h;
         diag_result_type r;
         if (op == tda_pkg::OP_LOAD_BASIS) begin
            basis_words[a*tda_pkg::MAX_DOF_DEF + b] = val;
         end else if (op == tda_pkg::OP_LOAD_HESS) begin
            hess_words[(v*tda_pkg::MAX_QUAD_DEF + a)*tda_pkg::MAX_QUAD_DEF + b] = val;
         end else if (op == tda_pkg::OP_QUERY) begin
            nd = (dofs_reg > tda_pkg::MAX_DOF_DEF) ? tda_pkg::MAX_DOF_DEF : dofs_reg;
            nq = (quad_reg > tda_pkg::MAX_QUAD_DEF) ? tda_pkg::MAX_QUAD_DEF : quad_reg;
            flag = 1'b0;
            acc = 0;
            if (a < nd && b < nd) begin
               for (int qx = 0; qx < nq; qx++) begin
                  inner = 0;
                  for (int qy = 0; qy < nq; qy++) begin
                     h = hess_words[(v*tda_pkg::MAX_QUAD_DEF + qx)*tda_pkg::MAX_QUAD_DEF + qy];
                     inner += (basis_sq(qy, b, flag) * h) >>> tda_pkg::FRAC_W;
                  end
                  inner = clip32(inner, flag);
                  acc += (basis_sq(qx, a, flag) * inner) >>> tda_pkg::FRAC_W;
               end
            end
            acc = clip32(longint'(val) + acc, flag);
            r.diag = acc[31:0];
            r.sat = flag;
            pending_diag.push_back(r);
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(logic signed [31:0] diag, logic sat);
         diag_result_type want;
         if (pending_diag.size() == 0) begin
            report_mismatch("unexpected result", diag, 32'h0);
         end else begin
            want = pending_diag.pop_front();
            if (diag !== want.diag) report_mismatch("diag_value", diag, want.diag);
            if (sat !== want.sat) report_mismatch("saturated", 32'(sat), 32'(want.sat));
         end
      endtask
   endclass

   // ---------------------------------------------------------------------------
   // Block under test.
   // ---------------------------------------------------------------------------
   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [1:0]                         req_operation;
   logic                               req_component;
   logic [tda_pkg::IDX_W-1:0]          req_index_a;
   logic [tda_pkg::IDX_W-1:0]          req_index_b;
   logic signed [tda_pkg::VALUE_W-1:0] req_value;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic signed [tda_pkg::VALUE_W-1:0] rsp_diag_value;
   logic                               rsp_saturated;
   logic                               csr_write_enable;
   logic                               csr_index;
   logic [tda_pkg::CFG_W-1:0]          csr_write_data;

   tensor_diag_assembly_2d u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_component    (req_component),
      .req_index_a      (req_index_a),
      .req_index_b      (req_index_b),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_diag_value   (rsp_diag_value),
      .rsp_saturated    (rsp_saturated),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   diag_scoreboard sb = new();

   // Shared control between the stimulus and the result side. When steady_flow
   // is set neither side draws random idle gaps, so back-to-back transfers are exercised.
   bit steady_flow;
   bit hold_off_request;
   bit rx_running;
   int idle_cycles;

   // ---------------------------------------------------------------------------
   // Watchdog: counts cycles with no transfer on either channel. A hang in the
   // block shows up here rather than as an endless simulation.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result side. Every result transfer is checked at the edge where it is
   // accepted; then the receiver draws how long to stall before the next one.
   // A hold-off request makes it refuse results for a long stretch, so that the
   // block's queue fills up and it has to stall the request channel.
   // ---------------------------------------------------------------------------
   initial begin : result_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      wait (rx_running);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_diag_value, rsp_saturated);
            stall_left = steady_flow ? 0 : $urandom_range(0, 4);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side helpers.
   // ---------------------------------------------------------------------------

   // Offers one item after a random gap and returns once it has been
   // transferred. Valid is left high so that a following item with no gap
   // goes out on the very next edge.
   task automatic send_item(logic [1:0] op, logic v, logic [2:0] a, logic [2:0] b,
                            logic signed [31:0] val);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_component <= v;
      req_index_a   <= a;
      req_index_b   <= b;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, v, a, b, val);
   endtask

   // Register writes only happen with the block idle, so the predictor can
   // take the new size at once. The enable drops for a cycle between writes.
   task automatic write_size(logic idx, logic [tda_pkg::CFG_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.set_size(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for every expected result, then idles on so that loads still in
   // the queue have retired before the sizes change.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Entry values: mostly a few units in Q16.16 so that sums stay meaningful,
   // sometimes the full 32-bit range so that saturation is reached.
   function automatic logic signed [31:0] entry_value(int wide_pct);
      if ($urandom_range(0, 99) < wide_pct) return $urandom;
      return $signed($urandom_range(0, 2**19)) - 2**18;
   endfunction

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         send_item(tda_pkg::OP_LOAD_BASIS, 1'($urandom), 3'($urandom), 3'($urandom),
                   entry_value(15));
      end else if (pick < 60) begin
         send_item(tda_pkg::OP_LOAD_HESS, 1'($urandom), 3'($urandom), 3'($urandom),
                   entry_value(15));
      end else if (pick < 96) begin
         send_item(tda_pkg::OP_QUERY, 1'($urandom), 3'($urandom), 3'($urandom),
                   entry_value(30));
      end else begin
         send_item(OP_UNUSED, 1'($urandom), 3'($urandom), 3'($urandom), $urandom);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic [tda_pkg::CFG_W-1:0] dofs_sel;
      logic [tda_pkg::CFG_W-1:0] quad_sel;
      req_valid        <= 1'b0;
      req_operation    <= tda_pkg::OP_LOAD_BASIS;
      req_component    <= 1'b0;
      req_index_a      <= '0;
      req_index_b      <= '0;
      req_value        <= '0;
      rsp_ready        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= tda_pkg::CSR_NUM_DOFS;
      csr_write_data   <= '0;
      reset            <= 1'b1;
      steady_flow      = 1'b0;
      hold_off_request = 1'b0;
      rx_running       = 1'b0;
      idle_cycles      = 0;
      sb.reset_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      rx_running = 1'b1;

      // The stores are undefined after reset, so every entry is written before
      // the first query can read it.
      for (int q = 0; q < tda_pkg::MAX_QUAD_DEF; q++)
         for (int d = 0; d < tda_pkg::MAX_DOF_DEF; d++)
            send_item(tda_pkg::OP_LOAD_BASIS, 1'b0, 3'(q), 3'(d), entry_value(5));
      for (int v = 0; v < 2; v++)
         for (int qx = 0; qx < tda_pkg::MAX_QUAD_DEF; qx++)
            for (int qy = 0; qy < tda_pkg::MAX_QUAD_DEF; qy++)
               send_item(tda_pkg::OP_LOAD_HESS, 1'(v), 3'(qx), 3'(qy), entry_value(5));

      // Directed part at the reset sizes: dof corners, both components, the
      // prior value at its extremes, and the unused operation.
      send_item(tda_pkg::OP_QUERY, 1'b0, 3'd0, 3'd0, 32'sd0);
      send_item(tda_pkg::OP_QUERY, 1'b1, 3'd7, 3'd7, 32'sh00010000);
      send_item(tda_pkg::OP_QUERY, 1'b0, 3'd0, 3'd7, 32'sh7FFFFFFF);
      send_item(tda_pkg::OP_QUERY, 1'b1, 3'd7, 3'd0, 32'sh80000000);
      send_item(OP_UNUSED, 1'b1, 3'd7, 3'd7, 32'shFFFFFFFF);
      // Largest and most negative basis and Hessian words drive the squares
      // and both partial sums into saturation.
      send_item(tda_pkg::OP_LOAD_BASIS, 1'b0, 3'd0, 3'd0, 32'sh7FFFFFFF);
      send_item(tda_pkg::OP_LOAD_HESS, 1'b0, 3'd0, 3'd0, 32'sh7FFFFFFF);
      send_item(tda_pkg::OP_QUERY, 1'b0, 3'd0, 3'd0, 32'sd0);
      send_item(tda_pkg::OP_LOAD_BASIS, 1'b0, 3'd7, 3'd7, 32'sh80000000);
      send_item(tda_pkg::OP_LOAD_HESS, 1'b1, 3'd7, 3'd7, 32'sh80000000);
      send_item(tda_pkg::OP_QUERY, 1'b1, 3'd7, 3'd7, 32'sh80000000);
      send_item(tda_pkg::OP_QUERY, 1'b1, 3'd7, 3'd0, 32'sh7FFFFFFF);
      drain();

      // Out-of-range dofs with a small size, then both sizes at zero, then
      // sizes above the maximum, which act as the maximum.
      write_size(tda_pkg::CSR_NUM_DOFS, 4'd1);
      write_size(tda_pkg::CSR_NUM_QUAD, 4'd1);
      send_item(tda_pkg::OP_QUERY, 1'b0, 3'd0, 3'd0, 32'sh00020000);
      send_item(tda_pkg::OP_QUERY, 1'b0, 3'd1, 3'd0, 32'sh00030000);
      send_item(tda_pkg::OP_QUERY, 1'b1, 3'd0, 3'd5, 32'sh7FFFFFFF);
      drain();
      write_size(tda_pkg::CSR_NUM_DOFS, 4'd0);
      write_size(tda_pkg::CSR_NUM_QUAD, 4'd0);
      send_item(tda_pkg::OP_QUERY, 1'b0, 3'd0, 3'd0, 32'sh80000000);
      drain();
      write_size(tda_pkg::CSR_NUM_DOFS, 4'd15);
      write_size(tda_pkg::CSR_NUM_QUAD, 4'd15);
      send_item(tda_pkg::OP_QUERY, 1'b1, 3'd7, 3'd7, 32'sd12345);
      drain();

      // Random phases. The first few use fixed sizes at the corners; the rest
      // draw sizes, the quadrature size mostly small so queries stay short. Phase 2 runs with no
      // idling and with the long receiver hold-off; phase 5 runs with no idling.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin dofs_sel = 4'd8;  quad_sel = 4'd8;  end
            1: begin dofs_sel = 4'd0;  quad_sel = 4'd3;  end
            2: begin dofs_sel = 4'd4;  quad_sel = 4'd0;  end
            3: begin dofs_sel = 4'd15; quad_sel = 4'd1;  end
            4: begin dofs_sel = 4'd2;  quad_sel = 4'd15; end
            default: begin
               dofs_sel = 4'($urandom_range(0, 15));
               quad_sel = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(1, 4));
            end
         endcase
         write_size(tda_pkg::CSR_NUM_DOFS, dofs_sel);
         write_size(tda_pkg::CSR_NUM_QUAD, quad_sel);
         steady_flow = (ph == 2 || ph == 5);
         if (ph == 2) hold_off_request = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) random_item();
         drain();
         steady_flow = 1'b0;
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tda_pkg.sv
hw/rtl/tda_front.sv
hw/rtl/tda_queue.sv
hw/rtl/tda_back.sv
hw/rtl/tensor_diag_assembly_2d.sv
tb/sv/testbench.sv
